@@ rtl/asrl_pkg.sv @@
package asrl_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int ADDR_W = 64;
  localparam int SYM_W  = 16;
  localparam int SPAN_W = 32;
  localparam int STAT_W = 3;
  localparam int CFG_W  = 64;
  localparam int CIDX_W = 2;

  localparam logic [SPAN_W-1:0] TAIL_SPAN_RESET = SPAN_W'(10000);

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED      = 3'd0;
  localparam logic [STAT_W-1:0] ST_OUT_OF_BOUNDS = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL          = 3'd2;
  localparam logic [STAT_W-1:0] ST_HIT           = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISS          = 3'd4;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_LOW_BOUND  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_HIGH_BOUND = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TAIL_SPAN  = 2'd2;

  // One table entry as held in the memory
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SYM_W-1:0]  sym;
  } entry_t;

endpackage

@@ rtl/address_to_symbol_range_lookup_core.sv @@
// Lookup: a check, then a binary search of S steps (S <= 13), each a table read and
// a compare, then the result word. Insert: same search, then each entry above the slot is
// moved up (read, then write) and the new entry placed. Rejected inserts and trivial
// misses go from the check to the result word. One word in flight; the next word is taken
// in the cycle after the result word is loaded; table reads return registered data.
// Reset (synchronous, rst_n low) clears state, fill count, out_valid; config gets defaults.
module address_to_symbol_range_lookup_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [asrl_pkg::ADDR_W-1:0]      in_address,
  input  logic [asrl_pkg::SYM_W-1:0]       in_symbol_id,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [asrl_pkg::STAT_W-1:0]      out_status,
  output logic [asrl_pkg::SYM_W-1:0]       out_hit_symbol,
  output logic [asrl_pkg::ADDR_W-1:0]      out_hit_offset,
  input  logic                             cfg_wr_en,
  input  logic [asrl_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [asrl_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int AW = asrl_pkg::ADDR_W;
  localparam int SW = asrl_pkg::SYM_W;
  localparam int CW = asrl_pkg::CNT_W;
  localparam int IW = asrl_pkg::IDX_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_SHRD  = 4'd4;
  localparam logic [3:0] S_SHWR  = 4'd5;
  localparam logic [3:0] S_PUT   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  // Control state
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Configuration
  logic [AW-1:0]             low_r, high_r;
  logic [asrl_pkg::SPAN_W-1:0] tail_r;

  // Item and search registers
  logic          kind_r, kind_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [SW-1:0] sym_r, sym_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, sh_r, sh_nxt;
  asrl_pkg::entry_t cand_r, cand_nxt;
  logic [AW-1:0] first_r, first_nxt, last_r, last_nxt;

  // Result registers
  logic [asrl_pkg::STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic [SW-1:0]               res_sym_r, res_sym_nxt;
  logic [AW-1:0]               res_off_r, res_off_nxt;
  logic [asrl_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [SW-1:0]               out_sym_r, out_sym_nxt;
  logic [AW-1:0]               out_off_r, out_off_nxt;

  // Table memory
  asrl_pkg::entry_t mem [asrl_pkg::TABLE_DEPTH];
  asrl_pkg::entry_t rd_data_r;
  asrl_pkg::entry_t mem_wdata;
  logic [IW-1:0]    rd_idx, mem_widx;
  logic             mem_we;

  // Shared datapath terms
  logic [CW-1:0] mid;
  logic [CW-1:0] sh_dec;
  logic [AW:0]   tail_diff;
  logic          tail_ok;
  logic          in_acc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_status     = out_stat_r;
  assign out_hit_symbol = out_sym_r;
  assign out_hit_offset = out_off_r;

  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign sh_dec    = sh_r - CW'(1);
  assign tail_diff = {1'b0, addr_r} - {1'b0, last_r};
  assign tail_ok   = tail_diff[AW] ||
                     (tail_diff[AW-1:0] < {{(AW-asrl_pkg::SPAN_W){1'b0}}, tail_r});

  // Read address: search midpoint, else the entry below the shift slot
  always_comb begin
    if (state_r == S_SRD) begin
      rd_idx = mid[IW-1:0];
    end else begin
      rd_idx = sh_dec[IW-1:0];
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wdata;
    end
    rd_data_r <= mem[rd_idx];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    sym_nxt       = sym_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    sh_nxt        = sh_r;
    cand_nxt      = cand_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    res_stat_nxt  = res_stat_r;
    res_sym_nxt   = res_sym_r;
    res_off_nxt   = res_off_r;
    out_stat_nxt  = out_stat_r;
    out_sym_nxt   = out_sym_r;
    out_off_nxt   = out_off_r;
    mem_we        = 1'b0;
    mem_widx      = sh_r[IW-1:0];
    mem_wdata     = rd_data_r;

    // Drop the output word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt  = in_kind;
          addr_nxt  = in_address;
          sym_nxt   = in_symbol_id;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_sym_nxt = '0;
        res_off_nxt = '0;
        lo_nxt      = '0;
        hi_nxt      = cnt_r;
        if (kind_r == asrl_pkg::KIND_INSERT) begin
          if (addr_r < low_r || addr_r > high_r) begin
            res_stat_nxt = asrl_pkg::ST_OUT_OF_BOUNDS;
            state_nxt    = S_OUT;
          end else if (cnt_r >= CW'(asrl_pkg::TABLE_DEPTH)) begin
            res_stat_nxt = asrl_pkg::ST_FULL;
            state_nxt    = S_OUT;
          end else begin
            state_nxt = S_SRD;
          end
        end else begin
          if (cnt_r == '0 || addr_r < first_r || !tail_ok) begin
            res_stat_nxt = asrl_pkg::ST_MISS;
            state_nxt    = S_OUT;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD: begin
        if (lo_r < hi_r) begin
          state_nxt = S_SCMP;
        end else if (kind_r == asrl_pkg::KIND_INSERT) begin
          sh_nxt = cnt_r;
          if (cnt_r == lo_r) begin
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_SHRD;
          end
        end else begin
          // Search ended just past the last entry at or below the query
          res_stat_nxt = asrl_pkg::ST_HIT;
          res_sym_nxt  = cand_r.sym;
          res_off_nxt  = addr_r - cand_r.addr;
          state_nxt    = S_OUT;
        end
      end
      S_SCMP: begin
        if (rd_data_r.addr <= addr_r) begin
          lo_nxt   = mid + CW'(1);
          cand_nxt = rd_data_r;
        end else begin
          hi_nxt = mid;
        end
        state_nxt = S_SRD;
      end
      S_SHRD: begin
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        // Move one entry up a slot
        mem_we   = 1'b1;
        mem_widx = sh_r[IW-1:0];
        sh_nxt   = sh_dec;
        if (sh_dec == lo_r) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_SHRD;
        end
      end
      S_PUT: begin
        mem_we         = 1'b1;
        mem_widx       = lo_r[IW-1:0];
        mem_wdata.addr = addr_r;
        mem_wdata.sym  = sym_r;
        cnt_nxt        = cnt_r + CW'(1);
        if (lo_r == '0) begin
          first_nxt = addr_r;
        end
        if (lo_r == cnt_r) begin
          last_nxt = addr_r;
        end
        res_stat_nxt = asrl_pkg::ST_INSERTED;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_sym_nxt   = res_sym_r;
          out_off_nxt   = res_off_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      low_r       <= '0;
      high_r      <= '1;
      tail_r      <= asrl_pkg::TAIL_SPAN_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          asrl_pkg::CFG_LOW_BOUND:  low_r  <= cfg_wdata;
          asrl_pkg::CFG_HIGH_BOUND: high_r <= cfg_wdata;
          asrl_pkg::CFG_TAIL_SPAN:  tail_r <= cfg_wdata[asrl_pkg::SPAN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    addr_r     <= addr_nxt;
    sym_r      <= sym_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    sh_r       <= sh_nxt;
    cand_r     <= cand_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    res_stat_r <= res_stat_nxt;
    res_sym_r  <= res_sym_nxt;
    res_off_r  <= res_off_nxt;
    out_stat_r <= out_stat_nxt;
    out_sym_r  <= out_sym_nxt;
    out_off_r  <= out_off_nxt;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(asrl_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + CW'(1) &&
                                 $past(state_r) == S_PUT))
    else $error("entry count moved outside an insert");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRD || state_r == S_SCMP) |-> (lo_r <= hi_r && hi_r <= cnt_r))
    else $error("search window out of order");

  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r != asrl_pkg::ST_HIT) |->
      (out_sym_r == '0 && out_off_r == '0))
    else $error("non-hit word carries symbol or offset");
`endif

endmodule
